// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int ItemW = 32;
	localparam int PriW  = 8;
	localparam int OccW  = 5;

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_FULL     = 2'd2,
		ST_UNDER    = 2'd3
	} status_t;

	typedef struct packed {
		logic                    func;
		logic signed [ItemW-1:0] item;
		logic [PriW-1:0]         priority_req;
	} req_t;

	typedef struct packed {
		logic signed [ItemW-1:0] removed_item;
		logic [1:0]              status;
		logic [OccW-1:0]         occupancy;
	} rsp_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic [PriW-1:0]         new_pri;
		logic signed [ItemW-1:0] new_item;
	} cell_ctl_t;

endpackage

// ===== src/spq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// valid/ready channels for operations and results
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
	logic          valid;
	logic          ready;
	spq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, loads the new pair or shifts
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                             clk,
	input  spq_pkg::cell_ctl_t               ctl,
	input  logic                             occupied,
	input  logic                             left_keep,
	input  logic signed [spq_pkg::ItemW-1:0] left_item,
	input  logic [spq_pkg::PriW-1:0]         left_pri,
	input  logic signed [spq_pkg::ItemW-1:0] right_item,
	input  logic [spq_pkg::PriW-1:0]         right_pri,
	output logic signed [spq_pkg::ItemW-1:0] item_q,
	output logic [spq_pkg::PriW-1:0]         pri_q,
	output logic                             keep
);
	import spq_pkg::*;

	// entry stays ahead of the new pair
	assign keep = occupied && (pri_q <= ctl.new_pri);

	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			if (left_keep) begin
				item_q <= ctl.new_item;
				pri_q  <= ctl.new_pri;
			end else begin
				item_q <= left_item;
				pri_q  <= left_pri;
			end
		end else if (ctl.rem) begin
			item_q <= right_item;
			pri_q  <= right_pri;
		end
	end

endmodule

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// the result of an operation is registered at its transfer
// throughput: one operation per cycle while results are taken, every cell compares
//   against the new priority in parallel and shifts one place in the same cycle
// a waiting result does not stall input while the sink takes it that cycle
// reset: arst_n clears the entry count and the result valid; slot contents
//   are left as they are and only read once written
// ----------------------------------------------------------------------------
// sorted_priority_queue
// min-first priority queue as a chain of shifting cells, stable on ties
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	spq_req_if.sink          req,
	spq_rsp_if.source        rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// entry count, the slots below it hold valid pairs in sorted order
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_nxt;
	logic [CW+4:0]  occ_ext;

	// result register
	logic           rsp_valid_q;
	rsp_t           rsp_data_q;

	logic           accept;
	logic           is_ins;
	logic           full;
	logic           empty;
	cell_ctl_t      ctl;

	logic signed [ItemW-1:0] item_arr [CAPACITY];
	logic [PriW-1:0]         pri_arr  [CAPACITY];
	logic [CAPACITY-1:0]     keep_vec;
	logic [CAPACITY-1:0]     occ_vec;

	// new transfer whenever the result register is free or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_ins = (req.data.func == FUNC_INSERT);
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	assign ctl.ins      = accept && is_ins && !full;
	assign ctl.rem      = accept && !is_ins && !empty;
	assign ctl.new_pri  = req.data.priority_req;
	assign ctl.new_item = req.data.item;

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.rem) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// occupancy is reported in five bits, wrapping for large capacities
	assign occ_ext = {5'd0, count_nxt};

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    lk;
		logic signed [ItemW-1:0] li;
		logic [PriW-1:0]         lp;
		logic signed [ItemW-1:0] ri;
		logic [PriW-1:0]         rp;

		assign occ_vec[i] = (count_q > CW'(i));

		// head cell sees the new pair as its left neighbour
		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign li = ctl.new_item;
			assign lp = ctl.new_pri;
		end else begin : g_body
			assign lk = keep_vec[i-1];
			assign li = item_arr[i-1];
			assign lp = pri_arr[i-1];
		end

		// tail cell has nothing behind it, it keeps its own (now unused) pair
		if (i == CAPACITY - 1) begin : g_tail
			assign ri = item_arr[i];
			assign rp = pri_arr[i];
		end else begin : g_mid
			assign ri = item_arr[i+1];
			assign rp = pri_arr[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ_vec[i]),
			.left_keep  (lk),
			.left_item  (li),
			.left_pri   (lp),
			.right_item (ri),
			.right_pri  (rp),
			.item_q     (item_arr[i]),
			.pri_q      (pri_arr[i]),
			.keep       (keep_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload, captured at each operation transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q.occupancy <= occ_ext[4:0];
			if (is_ins) begin
				rsp_data_q.removed_item <= '0;
				rsp_data_q.status       <= full ? ST_FULL : ST_INSERTED;
			end else if (empty) begin
				rsp_data_q.removed_item <= '0;
				rsp_data_q.status       <= ST_UNDER;
			end else begin
				rsp_data_q.removed_item <= item_arr[0];
				rsp_data_q.status       <= ST_REMOVED;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the queue");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> pri_arr[0] <= pri_arr[1])
		else $error("head pair out of order");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !accept)
		else $error("transfer taken while result stalled");
`endif

endmodule

// ===== test/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives insert and remove operations into the queue and checks every result
// against a behavioural copy of a stable min-first sorted list. It starts
// with a directed run through underflow, ties, field extremes and a full
// queue. Random bursts follow, each biased to fill, to drain or to neither, with random
// idle on both channels.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int Depth      = 16;
	localparam int RandomOps  = 1880;
	localparam int QuietLimit = 1000;
	localparam int TailCycles = 4;

	// idle styles, redrawn every few dozen transfers on each side
	typedef enum int {
		PACE_FLAT_OUT,
		PACE_LIGHT,
		PACE_HEAVY
	} pace_t;

	// how the priorities of one burst are spread
	typedef enum int {
		SPREAD_TIES,
		SPREAD_FULL,
		SPREAD_EDGES
	} spread_t;

	typedef struct {
		logic signed [ItemW-1:0] item;
		logic [PriW-1:0]         pri;
	} slot_t;

	typedef struct {
		req_t op;
		bit   settle;	// hold back until every outstanding result is in
	} pending_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// driven registers, known from time zero
	logic drv_valid = 1'b0;
	req_t drv_data  = '0;
	logic mon_ready = 1'b0;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	assign req_ch.valid = drv_valid;
	assign req_ch.data  = drv_data;
	assign rsp_ch.ready = mon_ready;

	sorted_priority_queue #(
		.CAPACITY(Depth)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	// ------------------------------------------------------------------------
	// shared state
	// ------------------------------------------------------------------------

	pending_t op_backlog[$];	// operations still to be offered
	rsp_t     due_results[$];	// predicted results, oldest first
	slot_t    sorted_slots[$];	// predicted queue contents, head at index 0

	int ops_sent      = 0;
	int results_taken = 0;
	int fail_count    = 0;
	int peak_occupancy = 0;
	int n_stored = 0, n_removed = 0, n_dropped = 0, n_underflow = 0;

	pace_t drv_pace = PACE_FLAT_OUT;
	int    drv_pace_left = 30;
	int    drv_idle = 0;
	pace_t mon_pace = PACE_FLAT_OUT;
	int    mon_pace_left = 30;
	int    mon_stall = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor: stable sorted insert, pop from the head
	// ------------------------------------------------------------------------

	function automatic rsp_t apply_op(req_t op);
		rsp_t  r;
		slot_t s;
		int    pos;
		r = '0;
		if (op.func == FUNC_INSERT) begin
			if (sorted_slots.size() >= Depth) begin
				// full: pair is dropped, contents untouched
				r.status = ST_FULL;
			end else begin
				// goes behind every entry of lower or equal priority number
				pos = 0;
				while (pos < sorted_slots.size() && sorted_slots[pos].pri <= op.priority_req)
					pos++;
				s.item = op.item;
				s.pri  = op.priority_req;
				sorted_slots.insert(pos, s);
				r.status = ST_INSERTED;
			end
		end else if (sorted_slots.size() == 0) begin
			r.status = ST_UNDER;
		end else begin
			s = sorted_slots.pop_front();
			r.removed_item = s.item;
			r.status       = ST_REMOVED;
		end
		r.occupancy = OccW'(sorted_slots.size());
		if (sorted_slots.size() > peak_occupancy)
			peak_occupancy = sorted_slots.size();
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic void queue_op(logic f, logic signed [ItemW-1:0] v,
			logic [PriW-1:0] p, bit settle);
		pending_t e;
		e.op.func         = f;
		e.op.item         = v;
		e.op.priority_req = p;
		e.settle          = settle;
		op_backlog.push_back(e);
	endfunction

	// mostly random, now and then one of the signed extremes, zero or minus one
	function automatic logic signed [ItemW-1:0] draw_item();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PriW-1:0] draw_pri(spread_t spread);
		case (spread)
			SPREAD_TIES:  return PriW'($urandom_range(0, 3));
			SPREAD_EDGES: return $urandom_range(0, 1) ? PriW'($urandom_range(0, 1))
			                                          : PriW'($urandom_range(254, 255));
			default:      return PriW'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_wait(pace_t pace);
		case (pace)
			PACE_FLAT_OUT: return 0;
			PACE_LIGHT:    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
			default:       return $urandom_range(0, 14);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// driver: offers the backlog on the operation channel
	// ------------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : driver
		int idle_left;
		int sent_now;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_data  <= '0;
			ops_sent  <= 0;
		end else if (!(drv_valid && !req_ch.ready)) begin
			// not stuck on an unaccepted operation
			idle_left = drv_idle;
			sent_now  = ops_sent;
			if (drv_valid) begin
				// transfer: predict now, result arrives later
				due_results.push_back(apply_op(drv_data));
				sent_now++;
				ops_sent <= sent_now;
				if (drv_pace_left == 0) begin
					drv_pace      = pace_t'($urandom_range(0, 2));
					drv_pace_left = $urandom_range(10, 60);
				end else begin
					drv_pace_left--;
				end
				idle_left = pick_wait(drv_pace);
			end
			if (idle_left > 0) begin
				drv_valid <= 1'b0;
				drv_idle  = idle_left - 1;
			end else if (op_backlog.size() > 0 &&
					(!op_backlog[0].settle || sent_now == results_taken)) begin
				drv_data  <= op_backlog[0].op;
				drv_valid <= 1'b1;
				void'(op_backlog.pop_front());
				drv_idle  = 0;
			end else begin
				drv_valid <= 1'b0;
				drv_idle  = 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: takes results and compares them with the oldest prediction
	// ------------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : monitor
		int   stall;
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			mon_ready     <= 1'b0;
			results_taken <= 0;
		end else begin
			stall = mon_stall;
			if (rsp_ch.valid && mon_ready) begin
				got = rsp_ch.data;
				results_taken <= results_taken + 1;
				case (got.status)
					ST_INSERTED: n_stored++;
					ST_REMOVED:  n_removed++;
					ST_FULL:     n_dropped++;
					default:     n_underflow++;
				endcase
				if (due_results.size() == 0) begin
					$display("%0t: result with no operation outstanding, actual %p", $time, got);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (got.removed_item !== want.removed_item) begin
						$display("%0t: removed_item mismatch, expected %0d, actual %0d",
							$time, want.removed_item, got.removed_item);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, got.status);
						fail_count++;
					end
					if (got.occupancy !== want.occupancy) begin
						$display("%0t: occupancy mismatch, expected %0d, actual %0d",
							$time, want.occupancy, got.occupancy);
						fail_count++;
					end
				end
				if (mon_pace_left == 0) begin
					mon_pace      = pace_t'($urandom_range(0, 2));
					mon_pace_left = $urandom_range(10, 60);
				end else begin
					mon_pace_left--;
				end
				stall = pick_wait(mon_pace);
			end
			if (stall > 0) begin
				mon_ready <= 1'b0;
				mon_stall = stall - 1;
			end else begin
				mon_ready <= 1'b1;
				mon_stall = 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without a transfer on either channel
	// ------------------------------------------------------------------------

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QuietLimit) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, quiet, due_results.size());
				$display("sorted_priority_queue regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------

	initial begin : stimulus
		logic [PriW-1:0] fill_pri[12];
		int      n_random;
		int      burst_len;
		int      insert_pct;
		int      k;
		int      total_ops;
		spread_t spread;
		fill_pri = '{8'd0, 8'd7, 8'd255, 8'd0, 8'd128, 8'd1,
		             8'd254, 8'd7, 8'd7, 8'd0, 8'd200, 8'd255};

		// directed: underflow on an empty queue, with all-ones in the ignored fields
		queue_op(FUNC_REMOVE, -32'sd1, 8'hff, 1'b0);
		// item extremes against priority extremes, with ties at both ends
		queue_op(FUNC_INSERT, 32'sh7fff_ffff, 8'd255, 1'b0);
		queue_op(FUNC_INSERT, 32'sh8000_0000, 8'd0, 1'b0);
		queue_op(FUNC_INSERT, -32'sd1, 8'd255, 1'b0);
		queue_op(FUNC_INSERT, 32'sh0000_0000, 8'd128, 1'b0);
		// twelve more fill it to the brim, many on tied priorities
		for (k = 0; k < 12; k++)
			queue_op(FUNC_INSERT, (k % 2) ? 32'sh5555_5555 + k : 32'shaaaa_aaaa + k,
				fill_pri[k], 1'b0);
		// full: dropped, then one out, one in, dropped again
		queue_op(FUNC_INSERT, 32'sh1234_5678, 8'd0, 1'b0);
		queue_op(FUNC_REMOVE, 32'sh0000_0000, 8'h00, 1'b0);
		queue_op(FUNC_INSERT, 32'sh0f0f_0f0f, 8'd255, 1'b0);
		queue_op(FUNC_INSERT, 32'sh7fff_ffff, 8'd255, 1'b0);
		for (k = 0; k < 4; k++)
			queue_op(FUNC_REMOVE, draw_item(), draw_pri(SPREAD_FULL), 1'b0);

		// random bursts, each leaning towards filling, draining or neither
		n_random = 0;
		while (n_random < RandomOps) begin
			burst_len = $urandom_range(20, 80);
			case ($urandom_range(0, 4))
				0:       insert_pct = 90;
				1:       insert_pct = 75;
				2:       insert_pct = 50;
				3:       insert_pct = 25;
				default: insert_pct = 10;
			endcase
			spread = spread_t'($urandom_range(0, 2));
			for (k = 0; k < burst_len && n_random < RandomOps; k++) begin
				queue_op(($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
					draw_item(), draw_pri(spread),
					k == 0 && (n_random == 0 || $urandom_range(0, 3) == 0));
				n_random++;
			end
		end
		total_ops = op_backlog.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every operation has had its result taken
		while (results_taken < total_ops)
			@(posedge clk);
		// let any stray result show up before the final check
		repeat (TailCycles) @(posedge clk);

		if (due_results.size() != 0) begin
			$display("%0t: %0d predicted results never arrived", $time, due_results.size());
			fail_count++;
		end

		$display("covered %0d operations: %0d stored, %0d removed, %0d dropped full, %0d underflow",
			ops_sent, n_stored, n_removed, n_dropped, n_underflow);
		$display("peak occupancy %0d of %0d, %0d mismatches", peak_occupancy, Depth, fail_count);
		if (fail_count == 0) begin
			$display("sorted_priority_queue regression: pass");
		end else begin
			$display("sorted_priority_queue regression: fail");
		end
		$finish;
	end

endmodule

// ===== sorted_priority_queue.f =====
src/spq_pkg.sv
src/spq_if.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
